FILE: rtl/cde_pkg.sv
// ----------------------------------------------------------------------------
// cde_pkg - capsule distance evaluator package
// Word widths, configuration register indexes, reset values and the
// request and response beat types shared by the evaluator.
// ----------------------------------------------------------------------------
package cde_pkg;

   // Fixed point format: signed words with FRAC_W fraction bits
   localparam int WORD_W = 32;
   localparam int FRAC_W = 16;

   // Configuration registers are one bit narrower than a word (unsigned)
   localparam int CFG_W = WORD_W - 1;

   // Squares and their sum, radicand and root widths
   localparam int SQ_W   = 2 * WORD_W;
   localparam int RAD_W  = 2 * WORD_W;
   localparam int ROOT_W = WORD_W;
   localparam int REM_W  = WORD_W + 3;

   // Register reset values: 1.0 and 0.4 (rounded half up)
   localparam logic [CFG_W-1:0] HALF_HEIGHT_RESET = CFG_W'(64'd1 << FRAC_W);
   localparam logic [CFG_W-1:0] RADIUS_RESET      =
      CFG_W'(((64'd4 << FRAC_W) + 64'd5) / 64'd10);

   // Register index codes
   typedef enum logic [0:0] {
      CSR_HALF_HEIGHT = 1'b0,
      CSR_RADIUS      = 1'b1
   } csr_index_type;

   // Request beat: one point
   typedef struct packed {
      logic signed [WORD_W-1:0] px;
      logic signed [WORD_W-1:0] py;
      logic signed [WORD_W-1:0] pz;
   } req_payload_type;

   // Response beat: distance and saturation flag
   typedef struct packed {
      logic signed [WORD_W-1:0] distance;
      logic                     saturated;
   } rsp_payload_type;

endpackage

FILE: rtl/capsule_distance_eval.sv
// ----------------------------------------------------------------------------
// capsule_distance_eval - signed distance from a point to a Y-axis capsule
// Clamps y to the capsule segment, sums the three squared offsets and takes
// a rounded integer square root one bit per stage, then subtracts the radius.
// ----------------------------------------------------------------------------
// A request beat passes 4 front stages, one square root stage per root
// bit, rounding, radius subtract and the output register. Throughput: one
// beat per cycle while the skid entry is empty, set by the fully pipelined
// root; a two-entry output stage keeps req_ready registered.
// Reset (synchronous, active high) empties the pipeline and sets half height
// to 1.0 and radius to 0.4.
module capsule_distance_eval
   import cde_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   // request channel
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   // response channel
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   // configuration write port
   input  logic            csr_we,
   input  csr_index_type   csr_addr,
   input  logic [CFG_W-1:0] csr_wdata
);

   localparam logic signed [WORD_W+1:0] DIST_MAX = (WORD_W+2)'((64'd1 << (WORD_W - 1)) - 1);
   localparam logic signed [WORD_W+1:0] DIST_MIN = -DIST_MAX - (WORD_W+2)'(1);

   // Configuration registers
   logic [CFG_W-1:0] half_height_ff;
   logic [CFG_W-1:0] radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_height_ff <= HALF_HEIGHT_RESET;
         radius_ff      <= RADIUS_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_HALF_HEIGHT: half_height_ff <= csr_wdata;
            CSR_RADIUS:      radius_ff      <= csr_wdata;
            default:         ;
         endcase
      end
   end

   // Pipeline advance: held only while the output skid entry is occupied
   logic pipe_en;
   logic skid_vld_ff;

   assign pipe_en   = !skid_vld_ff;
   assign req_ready = pipe_en;

   // Stage 1: clamp y to [-h, h] and take the axial offset
   logic signed [WORD_W-1:0] h_s;
   logic signed [WORD_W-1:0] h_neg;
   logic signed [WORD_W:0]   off_in;
   logic                     s1_vld_ff;
   logic signed [WORD_W-1:0] s1_x_ff, s1_off_ff, s1_z_ff;

   assign h_s   = signed'({1'b0, half_height_ff});
   assign h_neg = -h_s;

   always_comb begin
      if (req_data.py > h_s) begin
         off_in = {req_data.py[WORD_W-1], req_data.py} - {h_s[WORD_W-1], h_s};
      end else if (req_data.py < h_neg) begin
         off_in = {req_data.py[WORD_W-1], req_data.py} + {h_s[WORD_W-1], h_s};
      end else begin
         off_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_x_ff   <= req_data.px;
         s1_off_ff <= off_in[WORD_W-1:0];
         s1_z_ff   <= req_data.pz;
      end
   end

   // Stage 2: magnitudes (the most negative word maps to 2^(W-1) unsigned)
   logic              s2_vld_ff;
   logic [WORD_W-1:0] s2_mx_ff, s2_mo_ff, s2_mz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_mx_ff <= s1_x_ff[WORD_W-1]   ? unsigned'(-s1_x_ff)   : unsigned'(s1_x_ff);
         s2_mo_ff <= s1_off_ff[WORD_W-1] ? unsigned'(-s1_off_ff) : unsigned'(s1_off_ff);
         s2_mz_ff <= s1_z_ff[WORD_W-1]   ? unsigned'(-s1_z_ff)   : unsigned'(s1_z_ff);
      end
   end

   // Stage 3: three squares in parallel
   logic            s3_vld_ff;
   logic [SQ_W-1:0] s3_sx_ff, s3_so_ff, s3_sz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_sx_ff <= SQ_W'(s2_mx_ff) * SQ_W'(s2_mx_ff);
         s3_so_ff <= SQ_W'(s2_mo_ff) * SQ_W'(s2_mo_ff);
         s3_sz_ff <= SQ_W'(s2_mz_ff) * SQ_W'(s2_mz_ff);
      end
   end

   // Square root pipeline, one root bit per stage. Index 0 holds the sum of
   // squares (at most 3 * 2^(2W-2), so it never overflows the radicand width).
   logic              sq_vld_ff  [ROOT_W+1];
   logic [RAD_W-1:0]  rad_ff     [ROOT_W+1];
   logic [REM_W-1:0]  rem_ff     [ROOT_W+1];
   logic [ROOT_W-1:0] root_ff    [ROOT_W+1];

   // Stage 4: sum of squares
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else if (pipe_en) begin
         sq_vld_ff[0] <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rad_ff[0]  <= s3_sx_ff + s3_so_ff + s3_sz_ff;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_root
      logic [REM_W-1:0]  shifted;
      logic [REM_W-1:0]  trial;
      logic              take;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      // bring down the next pair of radicand bits and try root*4+1
      assign shifted = {rem_ff[k][REM_W-3:0], rad_ff[k][RAD_W-1 -: 2]};
      assign trial   = {1'b0, root_ff[k], 2'b01};
      assign take    = (shifted >= trial);
      assign rem_in  = take ? (shifted - trial) : shifted;
      assign root_in = {root_ff[k][ROOT_W-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k+1] <= 1'b0;
         end else if (pipe_en) begin
            sq_vld_ff[k+1] <= sq_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            rad_ff[k+1]  <= rad_ff[k] << 2;
            rem_ff[k+1]  <= rem_in;
            root_ff[k+1] <= root_in;
         end
      end
   end

   // Round to nearest: a remainder above the root means the next half is past
   logic              rnd_vld_ff;
   logic [ROOT_W:0]   rnd_root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         rnd_vld_ff <= sq_vld_ff[ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rnd_root_ff <= {1'b0, root_ff[ROOT_W]}
                      + (ROOT_W+1)'(rem_ff[ROOT_W] > REM_W'(root_ff[ROOT_W]));
      end
   end

   // Subtract the radius and saturate to the word range
   logic signed [WORD_W+1:0] dist_in;
   logic                     sat_in;
   logic signed [WORD_W-1:0] dist_sat_in;
   logic                     res_vld_ff;
   rsp_payload_type          res_ff;

   always_comb begin
      dist_in = signed'({1'b0, rnd_root_ff}) - signed'({3'b000, radius_ff});
      if (dist_in > DIST_MAX) begin
         sat_in      = 1'b1;
         dist_sat_in = DIST_MAX[WORD_W-1:0];
      end else if (dist_in < DIST_MIN) begin
         sat_in      = 1'b1;
         dist_sat_in = DIST_MIN[WORD_W-1:0];
      end else begin
         sat_in      = 1'b0;
         dist_sat_in = dist_in[WORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         res_vld_ff <= rnd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         res_ff.distance  <= dist_sat_in;
         res_ff.saturated <= sat_in;
      end
   end

   // Output register with a skid entry behind it
   logic            out_vld_ff;
   rsp_payload_type out_ff;
   rsp_payload_type skid_ff;
   logic            push;
   logic            out_free;

   assign push     = res_vld_ff && pipe_en;
   assign out_free = !out_vld_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (out_free) begin
         out_vld_ff  <= skid_vld_ff || push;
         skid_vld_ff <= 1'b0;
      end else if (push) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_vld_ff ? skid_ff : res_ff;
      end else if (push) begin
         skid_ff <= res_ff;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule
